FILE: design/dtp_pkg.sv
`timescale 1ns / 1ps

package dtp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned YearW   = 14;
  localparam int unsigned TwoW    = 7;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned TdataW  = 56;

  localparam logic [PosW-1:0]  ShapeLen = 5'd19;
  localparam logic [PosW-1:0]  PosMax   = 5'd31;

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharDash  = 8'h2d;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharColon = 8'h3a;
  // marks a position that takes any decimal digit
  localparam logic [CharW-1:0] DigitSlot = 8'h00;

  typedef enum logic [2:0] {
    FieldYear,
    FieldMonth,
    FieldDay,
    FieldHour,
    FieldMinute,
    FieldSecond,
    FieldNone
  } field_e;

  typedef struct packed {
    logic             ok;
    logic [YearW-1:0] year;
    logic [TwoW-1:0]  month;
    logic [TwoW-1:0]  day;
    logic [TwoW-1:0]  hour;
    logic [TwoW-1:0]  minute;
    logic [TwoW-1:0]  second;
  } result_t;

  function automatic logic [CharW-1:0] expected_char(input logic [PosW-1:0] pos);
    logic [CharW-1:0] c;
    case (pos) inside
      5'd4, 5'd7:   c = CharDash;
      5'd10:        c = CharSpace;
      5'd13, 5'd16: c = CharColon;
      default:      c = DigitSlot;
    endcase
    return c;
  endfunction

  function automatic field_e field_of(input logic [PosW-1:0] pos);
    field_e f;
    case (pos) inside
      [5'd0:5'd3]:  f = FieldYear;
      5'd5, 5'd6:   f = FieldMonth;
      5'd8, 5'd9:   f = FieldDay;
      5'd11, 5'd12: f = FieldHour;
      5'd14, 5'd15: f = FieldMinute;
      5'd17, 5'd18: f = FieldSecond;
      default:      f = FieldNone;
    endcase
    return f;
  endfunction

endpackage

FILE: design/dtp_parse.sv
`timescale 1ns / 1ps

// Shape checker and digit accumulators. State advances on step_i; res_o is the
// result that a NUL at char_i would produce from the current state.
module dtp_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [dtp_pkg::CharW-1:0]  char_i,
  output dtp_pkg::result_t           res_o
);

  logic [dtp_pkg::PosW-1:0]  pos_q, pos_d;
  logic                      err_q, err_d;
  logic [dtp_pkg::YearW-1:0] year_q, year_d;
  logic [dtp_pkg::TwoW-1:0]  month_q, month_d;
  logic [dtp_pkg::TwoW-1:0]  day_q, day_d;
  logic [dtp_pkg::TwoW-1:0]  hour_q, hour_d;
  logic [dtp_pkg::TwoW-1:0]  minute_q, minute_d;
  logic [dtp_pkg::TwoW-1:0]  second_q, second_d;

  logic                       is_nul;
  logic                       in_shape;
  logic                       is_digit;
  logic                       bad;
  logic                       ok;
  logic [dtp_pkg::CharW-1:0]  want;
  logic [dtp_pkg::CharW-1:0]  dchar;
  logic [dtp_pkg::DigitW-1:0] digit;
  dtp_pkg::field_e            field;

  function automatic logic [dtp_pkg::YearW-1:0] push_year(
    input logic [dtp_pkg::YearW-1:0]  acc,
    input logic [dtp_pkg::DigitW-1:0] d
  );
    return dtp_pkg::YearW'({acc, 3'b000}) + dtp_pkg::YearW'({acc, 1'b0})
           + dtp_pkg::YearW'(d);
  endfunction

  function automatic logic [dtp_pkg::TwoW-1:0] push_two(
    input logic [dtp_pkg::TwoW-1:0]   acc,
    input logic [dtp_pkg::DigitW-1:0] d
  );
    return dtp_pkg::TwoW'({acc, 3'b000}) + dtp_pkg::TwoW'({acc, 1'b0})
           + dtp_pkg::TwoW'(d);
  endfunction

  always_comb begin
    is_nul   = (char_i == dtp_pkg::CharNul);
    in_shape = (pos_q < dtp_pkg::ShapeLen);
    want     = dtp_pkg::expected_char(pos_q);
    field    = dtp_pkg::field_of(pos_q);
    is_digit = (char_i >= dtp_pkg::CharZero) && (char_i <= dtp_pkg::CharNine);
    dchar    = char_i - dtp_pkg::CharZero;
    digit    = dchar[dtp_pkg::DigitW-1:0];
    if (!in_shape) begin
      bad = 1'b1;
    end else if (want == dtp_pkg::DigitSlot) begin
      bad = !is_digit;
    end else begin
      bad = (char_i != want);
    end
    ok = !err_q && (pos_q == dtp_pkg::ShapeLen);
  end

  always_comb begin
    res_o.ok     = ok;
    res_o.year   = ok ? year_q   : '0;
    res_o.month  = ok ? month_q  : '0;
    res_o.day    = ok ? day_q    : '0;
    res_o.hour   = ok ? hour_q   : '0;
    res_o.minute = ok ? minute_q : '0;
    res_o.second = ok ? second_q : '0;
  end

  always_comb begin
    pos_d    = pos_q;
    err_d    = err_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    if (step_i) begin
      if (is_nul) begin
        pos_d    = '0;
        err_d    = 1'b0;
        year_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
        second_d = '0;
      end else begin
        err_d = err_q | bad;
        if (pos_q < dtp_pkg::PosMax) begin
          pos_d = pos_q + 5'd1;
        end
        if (in_shape && is_digit) begin
          case (field)
            dtp_pkg::FieldYear:   year_d   = push_year(year_q, digit);
            dtp_pkg::FieldMonth:  month_d  = push_two(month_q, digit);
            dtp_pkg::FieldDay:    day_d    = push_two(day_q, digit);
            dtp_pkg::FieldHour:   hour_d   = push_two(hour_q, digit);
            dtp_pkg::FieldMinute: minute_d = push_two(minute_q, digit);
            dtp_pkg::FieldSecond: second_d = push_two(second_q, digit);
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      err_q    <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end else begin
      pos_q    <= pos_d;
      err_q    <= err_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
    end
  end

endmodule

FILE: design/fixed_datetime_text_parser.sv
`timescale 1ns / 1ps

// Parses a NUL-terminated string of the form "YYYY-MM-DD HH:MM:SS".
// Slave channel: one character per beat on s_axis_tdata_i; a zero byte ends
// the string. Master channel: one result beat per string, sent for its NUL:
// ok flag plus year, month, day, hour, minute, second (all zero unless ok).
// Throughput: one character per cycle except while a NUL stalls; the input
// register, the shape/accumulate logic and the result register form a
// two-stage pipe. Path: a NUL accepted into the input register loads its
// result into the result register, which drives m_axis_tvalid_o.
// Stalls: characters other than NUL keep flowing while a result waits. A NUL
// waits in the input register until the result register is free, and the
// slave side then backs up.
// Reset: clears the position, the error flag, the accumulators and both
// valid flags; the next character is taken as position zero.
module fixed_datetime_text_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [dtp_pkg::CharW-1:0]   s_axis_tdata_i,   // [7:0] char_in
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [0] ok, [14:1] year_out, [21:15] month_out, [28:22] day_out,
  // [35:29] hour_out, [42:36] minute_out, [49:43] second_out, [55:50] zero
  output logic [dtp_pkg::TdataW-1:0]  m_axis_tdata_o
);

  logic                      in_vld_q;
  logic [dtp_pkg::CharW-1:0] char_q;
  logic                      out_vld_q;
  dtp_pkg::result_t          out_q;
  dtp_pkg::result_t          res;
  logic                      nul;
  logic                      adv;
  logic                      out_free;

  assign nul      = (char_q == dtp_pkg::CharNul);
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign adv      = in_vld_q && (!nul || out_free);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      char_q <= s_axis_tdata_i;
    end
  end

  dtp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .char_i (char_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && nul) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && nul) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b000000, out_q.second, out_q.minute, out_q.hour,
                            out_q.day, out_q.month, out_q.year, out_q.ok};

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[49:1] == '0)
    else $error("failed parse carries nonzero fields");

  a_nul_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && nul |=> out_vld_q)
    else $error("NUL step did not load a result");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(char_q))
    else $error("stalled character lost from input register");

endmodule
